// ===== sv/pnmhp_pkg.sv =====
// Shared constants, status codes and result type for the netpbm header parser.
`timescale 1ns / 1ps
package pnmhp_pkg;

  // Characters the parser looks for
  localparam logic [7:0] CH_P       = 8'h50;  // 'P'
  localparam logic [7:0] CH_5       = 8'h35;  // '5'
  localparam logic [7:0] CH_6       = 8'h36;  // '6'
  localparam logic [7:0] CH_HASH    = 8'h23;  // '#'
  localparam logic [7:0] CH_NL      = 8'h0A;  // newline
  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
  localparam int unsigned MAXVAL_OK = 255;

  // Result status codes
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_BAD_MAGIC = 3'd1;
  localparam logic [2:0] STATUS_BAD_MAX   = 3'd2;
  localparam logic [2:0] STATUS_OVERFLOW  = 3'd3;
  localparam logic [2:0] STATUS_TOO_LONG  = 3'd4;

  // One result, status in the lowest bits
  typedef struct packed {
    logic [8:0]  header_size;
    logic [15:0] height;
    logic [15:0] width;
    logic        is_rgb;
    logic [2:0]  status;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned RESULT_BYTES_W = ((RESULT_W + 7) / 8) * 8;

  function automatic logic is_dec_char(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

// ===== sv/pnm_header_parser.sv =====
// Top level of the streaming netpbm (P5/P6) header parser.
//
// Usage:
//   Header bytes enter on the s_axis channel, one per request; tuser marks
//   the first byte of a new header and restarts parsing with that byte.
//   Bytes outside a header (before a start or after a result) are dropped.
//   At most one result leaves on m_axis per header: status, colour flag,
//   width, height and header length, packed in tdata.
// Timing:
//   A byte is held in an input register, decoded against the parser state
//   once the output register can take a result, and any result is written
//   to the output register: m_axis_tvalid rises when that register loads.
//   Throughput is one byte per cycle while m_axis is not stalled; the
//   phase/accumulator update is a single pass of logic per byte.
// Reset:
//   rst_ni clears both registers and returns the parser to waiting for a
//   start byte.
// Stall:
//   While a result waits on m_axis, one more byte is taken into the input
//   register; that byte is processed once the result is taken.
`timescale 1ns / 1ps
module pnm_header_parser #(
  parameter int unsigned MAX_HEADER_BYTES = 256,
  parameter int unsigned DIM_BITS         = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tuser,   // [0] start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [3] is_rgb, [19:4] width, [35:20] height,
  // [44:36] header_size, [47:45] zero
  output logic [pnmhp_pkg::RESULT_BYTES_W-1:0] m_axis_tdata
);

  localparam int unsigned CNT_W  = $clog2(MAX_HEADER_BYTES + 1);
  localparam int unsigned CEXT_W = (CNT_W > 9) ? CNT_W : 9;
  localparam int unsigned DEXT_W = (DIM_BITS > 16) ? DIM_BITS : 16;

  typedef enum logic [3:0] {
    PH_IDLE, PH_MAG0, PH_MAG1, PH_MAG2, PH_FSTART,
    PH_COMMENT, PH_SKIP, PH_DIGITS, PH_TAIL, PH_DONE
  } phase_e;

  // Input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  // Parser state
  phase_e              phase_q, phase_d;
  logic [1:0]          field_q, field_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DIM_BITS-1:0] acc_q, acc_d;
  logic                ovs_q, ovs_d;
  logic                fov_q, fov_d;
  logic [DIM_BITS-1:0] width_q, width_d;
  logic [DIM_BITS-1:0] height_q, height_d;
  logic                col_q, col_d;

  // Output register
  logic                  out_valid_q;
  pnmhp_pkg::result_t    out_q;

  logic out_ready, step_en, accept;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign step_en       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = accept ? 1'b1 : (step_en ? 1'b0 : in_valid_q);

  // State seen by this byte, after a start request
  phase_e              ph_cur;
  logic [1:0]          fi_cur;
  logic [CNT_W-1:0]    cnt_cur, cnt_inc;
  logic [DIM_BITS-1:0] acc_cur, w_cur, h_cur;
  logic                ovs_cur, fov_cur, col_cur;

  assign ph_cur  = in_start_q ? PH_MAG0 : phase_q;
  assign fi_cur  = in_start_q ? 2'd0 : field_q;
  assign cnt_cur = in_start_q ? '0 : cnt_q;
  assign acc_cur = in_start_q ? '0 : acc_q;
  assign ovs_cur = in_start_q ? 1'b0 : ovs_q;
  assign fov_cur = in_start_q ? 1'b0 : fov_q;
  assign w_cur   = in_start_q ? '0 : width_q;
  assign h_cur   = in_start_q ? '0 : height_q;
  assign col_cur = in_start_q ? 1'b0 : col_q;
  assign cnt_inc = cnt_cur + CNT_W'(1);

  // Digit accumulate; a new field starts from zero
  logic                dg_cont;
  logic [DIM_BITS-1:0] dg_acc;
  logic                dg_over;

  assign dg_cont = (ph_cur == PH_DIGITS) || (ph_cur == PH_SKIP);

  pnmhp_digit #(
    .DIM_BITS(DIM_BITS)
  ) u_digit (
    .acc_i  (dg_cont ? acc_cur : '0),
    .over_i (dg_cont ? fov_cur : 1'b0),
    .digit_i(in_byte_q[3:0]),
    .acc_o  (dg_acc),
    .over_o (dg_over)
  );

  logic       b_digit;
  logic       emit;
  logic [2:0] emit_status;

  assign b_digit = pnmhp_pkg::is_dec_char(in_byte_q);

  // Per-byte phase update
  always_comb begin
    phase_d     = ph_cur;
    field_d     = fi_cur;
    cnt_d       = cnt_cur;
    acc_d       = acc_cur;
    ovs_d       = ovs_cur;
    fov_d       = fov_cur;
    width_d     = w_cur;
    height_d    = h_cur;
    col_d       = col_cur;
    emit        = 1'b0;
    emit_status = pnmhp_pkg::STATUS_OK;

    if (ph_cur != PH_IDLE && ph_cur != PH_DONE) begin
      cnt_d = cnt_inc;
      unique case (ph_cur)
        PH_MAG0: begin
          if (in_byte_q == pnmhp_pkg::CH_P) begin
            phase_d = PH_MAG1;
          end else begin
            emit = 1'b1;
            emit_status = pnmhp_pkg::STATUS_BAD_MAGIC;
          end
        end
        PH_MAG1: begin
          if (in_byte_q == pnmhp_pkg::CH_5) begin
            col_d   = 1'b0;
            phase_d = PH_MAG2;
          end else if (in_byte_q == pnmhp_pkg::CH_6) begin
            col_d   = 1'b1;
            phase_d = PH_MAG2;
          end else begin
            emit = 1'b1;
            emit_status = pnmhp_pkg::STATUS_BAD_MAGIC;
          end
        end
        PH_MAG2: begin
          if (in_byte_q == pnmhp_pkg::CH_NL) begin
            field_d = 2'd0;
            phase_d = PH_FSTART;
          end else begin
            emit = 1'b1;
            emit_status = pnmhp_pkg::STATUS_BAD_MAGIC;
          end
        end
        PH_FSTART: begin
          acc_d = '0;
          fov_d = 1'b0;
          if (in_byte_q == pnmhp_pkg::CH_HASH) begin
            phase_d = PH_COMMENT;
          end else if (b_digit) begin
            acc_d   = dg_acc;
            fov_d   = dg_over;
            phase_d = PH_DIGITS;
          end else begin
            phase_d = PH_SKIP;
          end
        end
        PH_COMMENT: begin
          if (in_byte_q == pnmhp_pkg::CH_NL) phase_d = PH_FSTART;
        end
        PH_SKIP: begin
          if (b_digit) begin
            acc_d   = dg_acc;
            fov_d   = dg_over;
            phase_d = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          if (b_digit) begin
            acc_d = dg_acc;
            fov_d = dg_over;
          end else if (fi_cur < 2'd2) begin
            // field done: store it, this byte opens the next field
            if (fi_cur == 2'd0) width_d = acc_cur;
            else height_d = acc_cur;
            ovs_d   = ovs_cur | fov_cur;
            field_d = fi_cur + 2'd1;
            acc_d   = '0;
            fov_d   = 1'b0;
            if (in_byte_q == pnmhp_pkg::CH_HASH) phase_d = PH_COMMENT;
            else phase_d = PH_SKIP;
          end else if (acc_cur != DIM_BITS'(pnmhp_pkg::MAXVAL_OK) || fov_cur) begin
            emit = 1'b1;
            emit_status = pnmhp_pkg::STATUS_BAD_MAX;
          end else if (in_byte_q == pnmhp_pkg::CH_NL) begin
            emit = 1'b1;
            emit_status = ovs_cur ? pnmhp_pkg::STATUS_OVERFLOW : pnmhp_pkg::STATUS_OK;
          end else begin
            phase_d = PH_TAIL;
          end
        end
        PH_TAIL: begin
          if (in_byte_q == pnmhp_pkg::CH_NL) begin
            emit = 1'b1;
            emit_status = ovs_cur ? pnmhp_pkg::STATUS_OVERFLOW : pnmhp_pkg::STATUS_OK;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase

      // length limit reached without a result
      if (!emit && phase_d != PH_IDLE && cnt_inc >= CNT_W'(MAX_HEADER_BYTES)) begin
        emit = 1'b1;
        emit_status = pnmhp_pkg::STATUS_TOO_LONG;
      end
      if (emit) phase_d = PH_DONE;
    end
  end

  // Result assembly
  pnmhp_pkg::result_t  res;
  logic [CEXT_W-1:0]   size_ext;
  logic [DEXT_W-1:0]   w_ext, h_ext;

  assign size_ext = CEXT_W'(cnt_d);
  assign w_ext    = DEXT_W'(width_d);
  assign h_ext    = DEXT_W'(height_d);

  always_comb begin
    res.status      = emit_status;
    res.is_rgb      = (emit_status == pnmhp_pkg::STATUS_BAD_MAGIC) ? 1'b0 : col_d;
    res.width       = w_ext[15:0];
    res.height      = h_ext[15:0];
    res.header_size = (emit_status == pnmhp_pkg::STATUS_OK) ? size_ext[8:0] : 9'd0;
  end

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      in_byte_q   <= '0;
      in_start_q  <= 1'b0;
      phase_q     <= PH_IDLE;
      field_q     <= '0;
      cnt_q       <= '0;
      acc_q       <= '0;
      ovs_q       <= 1'b0;
      fov_q       <= 1'b0;
      width_q     <= '0;
      height_q    <= '0;
      col_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (accept) begin
        in_byte_q  <= s_axis_tdata;
        in_start_q <= s_axis_tuser;
      end
      if (step_en) begin
        phase_q  <= phase_d;
        field_q  <= field_d;
        cnt_q    <= cnt_d;
        acc_q    <= acc_d;
        ovs_q    <= ovs_d;
        fov_q    <= fov_d;
        width_q  <= width_d;
        height_q <= height_d;
        col_q    <= col_d;
      end
      if (step_en && emit) begin
        out_valid_q <= 1'b1;
        out_q       <= res;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = pnmhp_pkg::RESULT_BYTES_W'(out_q);

endmodule

// ===== sv/pnmhp_digit.sv =====
// Decimal accumulate step: acc * 10 + digit, saturating at the field maximum.
`timescale 1ns / 1ps
module pnmhp_digit #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic [DIM_BITS-1:0] acc_i,
  input  logic                over_i,
  input  logic [3:0]          digit_i,
  output logic [DIM_BITS-1:0] acc_o,
  output logic                over_o
);

  localparam int unsigned SUM_W = DIM_BITS + 4;

  logic [SUM_W-1:0] sum;
  logic             sat;

  // acc * 10 as (acc << 3) + (acc << 1)
  assign sum = ({1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0}) + {{(SUM_W - 4){1'b0}}, digit_i};
  assign sat = sum > {4'b0000, {DIM_BITS{1'b1}}};

  assign acc_o  = sat ? {DIM_BITS{1'b1}} : sum[DIM_BITS-1:0];
  assign over_o = over_i | sat;

endmodule

// ===== sv/pnmhp_checker.sv =====
// Port-level checks for the netpbm header parser, bound to the top level.
`timescale 1ns / 1ps
module pnmhp_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Status is one of the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] == pnmhp_pkg::STATUS_OK ||
                       m_axis_tdata[2:0] == pnmhp_pkg::STATUS_BAD_MAGIC ||
                       m_axis_tdata[2:0] == pnmhp_pkg::STATUS_BAD_MAX ||
                       m_axis_tdata[2:0] == pnmhp_pkg::STATUS_OVERFLOW ||
                       m_axis_tdata[2:0] == pnmhp_pkg::STATUS_TOO_LONG))
    else $error("undefined status");

  // Bad magic never reaches the colour flag or the dimension fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == pnmhp_pkg::STATUS_BAD_MAGIC
      |-> m_axis_tdata[35:3] == 33'd0)
    else $error("bad magic with colour or dimensions");

  // Only a good header carries a length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] != pnmhp_pkg::STATUS_OK
      |-> m_axis_tdata[44:36] == 9'd0)
    else $error("failed header with nonzero length");

endmodule

bind pnm_header_parser pnmhp_props u_pnmhp_props (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ===== tb/pnmhp_checker.sv =====
// Scoreboard for the netpbm header parser: predicts every result and compares it.
`timescale 1ns / 1ps
module pnmhp_checker #(
  parameter int unsigned MAX_HEADER_BYTES = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  input  logic                                 s_axis_tready_i,
  input  logic [7:0]                           s_axis_tdata_i,
  input  logic                                 s_axis_tuser_i,
  input  logic                                 m_axis_tvalid_i,
  input  logic                                 m_axis_tready_i,
  input  logic [pnmhp_pkg::RESULT_BYTES_W-1:0] m_axis_tdata_i,
  output int unsigned                          fails_o,
  output int unsigned                          waiting_o,
  output int unsigned                          compared_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_MAG0, PH_MAG1, PH_MAG2, PH_FSTART,
    PH_COMMENT, PH_SKIP, PH_DIGITS, PH_TAIL, PH_DONE
  } parse_phase_e;

  // Shadow copy of the parser state
  parse_phase_e ph;
  logic [1:0]   fld;
  logic [8:0]   nbytes;
  logic [15:0]  acc;
  logic         any_ovf;
  logic         fld_ovf;
  logic [15:0]  wid;
  logic [15:0]  hgt;
  logic         rgb;

  pnmhp_pkg::result_t headers_q[$];   // predicted header results, oldest first
  int unsigned        nfail;
  int unsigned        ncmp;

  task automatic report(string what, longint unsigned got, longint unsigned want);
    nfail++;
    $display("[%0t] result %0d: %s mismatch, got %0d, expected %0d",
             $time, ncmp, what, got, want);
  endtask

  task automatic clear_parser();
    ph      = PH_IDLE;
    fld     = '0;
    nbytes  = '0;
    acc     = '0;
    any_ovf = 1'b0;
    fld_ovf = 1'b0;
    wid     = '0;
    hgt     = '0;
    rgb     = 1'b0;
  endtask

  // Record one header result and stop parsing until the next start
  task automatic post(input logic [2:0] status);
    pnmhp_pkg::result_t r;
    r.status      = status;
    r.is_rgb      = (status == pnmhp_pkg::STATUS_BAD_MAGIC) ? 1'b0 : rgb;
    r.width       = wid;
    r.height      = hgt;
    r.header_size = (status == pnmhp_pkg::STATUS_OK) ? nbytes : '0;
    headers_q.push_back(r);
    ph = PH_DONE;
  endtask

  // Decimal accumulate, saturating at the 16-bit maximum
  task automatic add_digit(input logic [7:0] b);
    int unsigned v;
    v = int'(acc) * 10 + int'(b - pnmhp_pkg::CH_ZERO);
    if (v > 65535) begin
      v       = 65535;
      fld_ovf = 1'b1;
    end
    acc = v[15:0];
  endtask

  // First byte of a field: comment, digit or something to skip
  task automatic open_field(input logic [7:0] b);
    acc     = '0;
    fld_ovf = 1'b0;
    if (b == pnmhp_pkg::CH_HASH) begin
      ph = PH_COMMENT;
    end else if (b >= pnmhp_pkg::CH_ZERO && b <= pnmhp_pkg::CH_NINE) begin
      add_digit(b);
      ph = PH_DIGITS;
    end else begin
      ph = PH_SKIP;
    end
  endtask

  task automatic close_header();
    if (any_ovf) post(pnmhp_pkg::STATUS_OVERFLOW);
    else post(pnmhp_pkg::STATUS_OK);
  endtask

  // Advance the shadow parser by one accepted byte
  task automatic step_parser(input logic [7:0] b, input logic first);
    if (first) begin
      clear_parser();
      ph = PH_MAG0;
    end
    if (ph == PH_IDLE || ph == PH_DONE) return;
    nbytes++;
    case (ph)
      PH_MAG0: begin
        if (b == pnmhp_pkg::CH_P) ph = PH_MAG1;
        else post(pnmhp_pkg::STATUS_BAD_MAGIC);
      end
      PH_MAG1: begin
        if (b == pnmhp_pkg::CH_5) begin
          rgb = 1'b0;
          ph  = PH_MAG2;
        end else if (b == pnmhp_pkg::CH_6) begin
          rgb = 1'b1;
          ph  = PH_MAG2;
        end else begin
          post(pnmhp_pkg::STATUS_BAD_MAGIC);
        end
      end
      PH_MAG2: begin
        if (b == pnmhp_pkg::CH_NL) begin
          fld = '0;
          ph  = PH_FSTART;
        end else begin
          post(pnmhp_pkg::STATUS_BAD_MAGIC);
        end
      end
      PH_FSTART: open_field(b);
      PH_COMMENT: begin
        if (b == pnmhp_pkg::CH_NL) ph = PH_FSTART;
      end
      PH_SKIP: begin
        if (b >= pnmhp_pkg::CH_ZERO && b <= pnmhp_pkg::CH_NINE) begin
          add_digit(b);
          ph = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (b >= pnmhp_pkg::CH_ZERO && b <= pnmhp_pkg::CH_NINE) begin
          add_digit(b);
        end else if (fld < 2) begin
          // width or height done; this byte opens the next field
          if (fld == 0) wid = acc;
          else hgt = acc;
          if (fld_ovf) any_ovf = 1'b1;
          fld++;
          open_field(b);
        end else if (acc != 16'(pnmhp_pkg::MAXVAL_OK) || fld_ovf) begin
          post(pnmhp_pkg::STATUS_BAD_MAX);
        end else if (b == pnmhp_pkg::CH_NL) begin
          close_header();
        end else begin
          ph = PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (b == pnmhp_pkg::CH_NL) close_header();
      end
      default: ;
    endcase
    if (ph != PH_DONE && int'(nbytes) >= MAX_HEADER_BYTES) post(pnmhp_pkg::STATUS_TOO_LONG);
  endtask

  // Compare one delivered result against the oldest prediction
  task automatic check_result(input logic [pnmhp_pkg::RESULT_BYTES_W-1:0] data);
    pnmhp_pkg::result_t got;
    pnmhp_pkg::result_t want;
    got = data[pnmhp_pkg::RESULT_W-1:0];
    if (headers_q.size() == 0) begin
      report("unexpected result (status)", got.status, 0);
      return;
    end
    want = headers_q.pop_front();
    ncmp++;
    if (got.status != want.status) report("status", got.status, want.status);
    if (got.is_rgb != want.is_rgb) report("is_rgb", got.is_rgb, want.is_rgb);
    if (got.width != want.width) report("width", got.width, want.width);
    if (got.height != want.height) report("height", got.height, want.height);
    if (got.header_size != want.header_size) begin
      report("header_size", got.header_size, want.header_size);
    end
    if (data[pnmhp_pkg::RESULT_BYTES_W-1:pnmhp_pkg::RESULT_W] != '0) begin
      report("padding", data[pnmhp_pkg::RESULT_BYTES_W-1:pnmhp_pkg::RESULT_W], 0);
    end
  endtask

  // Results go first: a byte taken at this edge cannot have a result yet
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      headers_q.delete();
      nfail = 0;
      ncmp  = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_result(m_axis_tdata_i);
      if (s_axis_tvalid_i && s_axis_tready_i) step_parser(s_axis_tdata_i, s_axis_tuser_i);
    end
    fails_o    <= nfail;
    waiting_o  <= headers_q.size();
    compared_o <= ncmp;
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the netpbm header parser: clock, reset, traffic and verdict.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned HDR_LIMIT   = 256;
  localparam int unsigned ITEM_TARGET = 1850;
  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic                                 clk_i         = 1'b0;
  logic                                 rst_ni        = 1'b0;
  logic                                 s_axis_tvalid = 1'b0;
  logic                                 s_axis_tready;
  logic [7:0]                           s_axis_tdata  = '0;
  logic                                 s_axis_tuser  = 1'b0;
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready = 1'b0;
  logic [pnmhp_pkg::RESULT_BYTES_W-1:0] m_axis_tdata;

  int unsigned fails;
  int unsigned waiting;
  int unsigned compared;

  logic        hold_go = 1'b0;
  logic [7:0]  hdr_q[$];       // bytes of the header being built
  int unsigned n_bytes   = 0;
  int unsigned n_headers = 0;
  int unsigned n_long    = 0;
  int unsigned idle_cnt  = 0;

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pnm_header_parser #(
    .MAX_HEADER_BYTES(HDR_LIMIT),
    .DIM_BITS        (16)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  pnmhp_checker #(
    .MAX_HEADER_BYTES(HDR_LIMIT)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .fails_o        (fails),
    .waiting_o      (waiting),
    .compared_o     (compared)
  );

  // Mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_text(input string s);
    foreach (s[i]) hdr_q.push_back(s[i]);
  endtask

  task automatic push_num(input int unsigned n);
    push_text($sformatf("%0d", n));
  endtask

  // Random bytes; inside a comment a newline would end it early
  task automatic push_filler(input int unsigned n, input bit no_nl);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (no_nl && b == pnmhp_pkg::CH_NL) b = 8'h20;
      hdr_q.push_back(b);
    end
  endtask

  task automatic push_nondigit(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom_range(0, 255));
      while (b >= pnmhp_pkg::CH_ZERO && b <= pnmhp_pkg::CH_NINE);
      hdr_q.push_back(b);
    end
  endtask

  // One byte request; waits for the handshake, then maybe idles
  task automatic send_one(input logic [7:0] b, input logic first, input bit pace);
    int unsigned gap;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = pace ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_header(input bit pace);
    foreach (hdr_q[i]) send_one(hdr_q[i], i == 0, pace);
    n_bytes += hdr_q.size();
    n_headers++;
    hdr_q.delete();
  endtask

  task automatic push_dim();
    case ($urandom_range(0, 9))
      6, 7:    push_num($urandom_range(0, 65535));
      8:       push_num($urandom_range(65535, 70000));
      9: begin
        push_text("000");
        push_num($urandom_range(0, 99999));
      end
      default: push_num($urandom_range(0, 999));
    endcase
  endtask

  // Random header: mostly well formed, some broken, a few near the size limit
  task automatic make_header();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      // total length 254..257 bytes, straddling the header length limit
      len = $urandom_range(254, 257);
      push_text("P5\n");
      hdr_q.push_back(pnmhp_pkg::CH_HASH);
      push_filler(len - 13, 1);
      hdr_q.push_back(pnmhp_pkg::CH_NL);
      push_text("1 1 255\n");
      n_long++;
    end else if (r < 9) begin
      // raw noise after a start
      hdr_q.push_back($urandom_range(0, 1) ? pnmhp_pkg::CH_P : 8'($urandom_range(0, 255)));
      push_filler($urandom_range(0, 10), 0);
    end else begin
      hdr_q.push_back(pnmhp_pkg::CH_P);
      hdr_q.push_back($urandom_range(0, 1) ? pnmhp_pkg::CH_6 : pnmhp_pkg::CH_5);
      hdr_q.push_back(pnmhp_pkg::CH_NL);
      if ($urandom_range(0, 11) == 0) begin
        hdr_q[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
      end
      for (int f = 0; f < 3; f++) begin
        if (f == 0 && $urandom_range(0, 39) == 0) begin
          hdr_q.push_back(pnmhp_pkg::CH_HASH);
          push_filler($urandom_range(150, 250), 1);
          hdr_q.push_back(pnmhp_pkg::CH_NL);
          n_long++;
        end
        // comment lines at field start, else a plain separator
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 2)) begin
            hdr_q.push_back(pnmhp_pkg::CH_HASH);
            push_filler($urandom_range(0, 8), 1);
            hdr_q.push_back(pnmhp_pkg::CH_NL);
          end
        end else if (f != 0 && $urandom_range(0, 19) != 0) begin
          push_nondigit(1);
        end
        if ($urandom_range(0, 3) == 0) push_nondigit($urandom_range(1, 3));
        if (f < 2) begin
          push_dim();
        end else begin
          case ($urandom_range(0, 9))
            8:       push_num($urandom_range(0, 300));
            9:       push_num($urandom);
            default: push_text("255");
          endcase
        end
      end
      r = $urandom_range(0, 99);
      if (r < 80) begin
        hdr_q.push_back(pnmhp_pkg::CH_NL);
      end else if (r < 95) begin
        push_nondigit(1);
        push_filler($urandom_range(0, 5), 1);
        hdr_q.push_back(pnmhp_pkg::CH_NL);
      end
      if ($urandom_range(0, 11) == 0) begin
        len = $urandom_range(1, hdr_q.size() - 1);
        while (hdr_q.size() > len) void'(hdr_q.pop_back());
      end
    end
  endtask

  // Result side: random stalls, calm stretches, one long hold-off
  initial begin
    int unsigned stall;
    int unsigned cyc;
    bit          held;
    stall = 0;
    cyc   = 0;
    held  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_go && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        stall = ((cyc % 1000) < 200) ? 0 : pick_gap();
        m_axis_tready <= (stall == 0);
        if (stall != 0) stall--;
      end
    end
  end

  // Watchdog: no request on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("Watchdog: no traffic for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, waiting);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // byte before any start is dropped
    send_one(8'hFF, 1'b0, 1'b0);
    // comment at width start, zero and full-scale dimensions
    push_text("P6\n#c9\n0 65535 255\n");
    send_header(1'b1);
    // bytes after a result are dropped
    send_one(pnmhp_pkg::CH_P, 1'b0, 1'b0);
    // bad magic at each of the three positions
    push_text("X");
    send_header(1'b0);
    push_text("P7");
    send_header(1'b0);
    push_text("P6 ");
    send_header(1'b0);
    // width overflow, then overflowed maxval
    push_text("P5\n65536 1 255\n");
    send_header(1'b1);
    push_text("P5\n1 1 9999999\n");
    send_header(1'b0);
    // restart in mid header, then a '#' inside a field gap and trailing text
    push_text("P5\n12");
    send_header(1'b0);
    push_text("P5\n2 x#9\n255 t\n");
    send_header(1'b1);

    while (n_bytes < ITEM_TARGET) begin
      if (!hold_go && n_bytes > ITEM_TARGET / 2) hold_go <= 1'b1;
      make_header();
      send_header($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_one(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
    end
    s_axis_tvalid <= 1'b0;

    // let the last prediction reach the outstanding count before draining
    repeat (2) @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d header bytes in %0d headers (%0d long), %0d results checked",
             n_bytes, n_headers, n_long, compared);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fails);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
